FILE: src/pdd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the postings delta decoder.
package pdd_pkg;

    localparam int MAX_DOCS_DEFAULT = 65536;
    localparam int DOC_SPACE        = 65536;
    localparam int DOC_W            = 16;
    localparam int DOC_ADDR_MAX_W   = 24;
    localparam int WORD_W           = 32;
    localparam int FREQ_W           = 32;
    localparam int KIND_W           = 2;
    localparam int QUEUE_DEPTH      = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_EMIT   = 2'd0,
        OP_CHECK  = 2'd1,
        OP_DELETE = 2'd2
    } t_op_code;

    // For a delete the doc field holds the bitmap address.
    typedef struct packed {
        t_op_code                  code;
        logic [DOC_ADDR_MAX_W-1:0] doc;
        logic [FREQ_W-1:0]         freq;
        logic                      last;
        logic                      error;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_push;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_queue_head;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

FILE: src/pdd_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, tracks the term state and queues operations.
module pdd_front #(
    parameter int MAX_DOCS = pdd_pkg::MAX_DOCS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [pdd_pkg::KIND_W-1:0]  i_kind,
    input  logic [pdd_pkg::WORD_W-1:0]  i_value,
    output logic                        o_ready,
    input  pdd_pkg::t_back_status       i_back_status,
    input  logic                        i_queue_full,
    output pdd_pkg::t_push              o_push
);
    import pdd_pkg::*;

    localparam logic [WORD_W-1:0] DocLimit =
        (MAX_DOCS < DOC_SPACE) ? WORD_W'(MAX_DOCS) : WORD_W'(DOC_SPACE);
    localparam logic [WORD_W-1:0] MaxDocs = WORD_W'(MAX_DOCS);

    logic [DOC_W-1:0]  r_doc, n_doc;
    logic [WORD_W-1:0] r_remaining, n_remaining;
    logic              r_awaiting, n_awaiting;

    logic              accept;
    logic              push_valid;
    t_op               push_op;
    logic [WORD_W-1:0] rem_dec;
    logic              is_last;
    logic [WORD_W-1:0] sum;

    assign o_ready = !i_queue_full && !i_back_status.clearing;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_doc       = r_doc;
        n_remaining = r_remaining;
        n_awaiting  = r_awaiting;
        push_valid  = 1'b0;
        push_op     = '0;
        rem_dec     = r_remaining - WORD_W'(1);
        is_last     = (rem_dec == '0);
        sum         = WORD_W'(r_doc) + WORD_W'(i_value[WORD_W-1:1]);
        case (t_kind'(i_kind))
            KIND_START: begin
                n_remaining = i_value;
                n_doc       = '0;
                n_awaiting  = 1'b0;
            end
            KIND_WORD: begin
                if (r_awaiting) begin
                    n_awaiting   = 1'b0;
                    n_remaining  = rem_dec;
                    push_valid   = 1'b1;
                    push_op.code = OP_CHECK;
                    push_op.doc  = DOC_ADDR_MAX_W'(r_doc);
                    push_op.freq = i_value;
                    push_op.last = is_last;
                end else if (r_remaining == '0) begin
                    push_valid    = 1'b1;
                    push_op.code  = OP_EMIT;
                    push_op.error = 1'b1;
                end else if (sum >= DocLimit) begin
                    n_remaining   = '0;
                    n_awaiting    = 1'b0;
                    push_valid    = 1'b1;
                    push_op.code  = OP_EMIT;
                    push_op.last  = 1'b1;
                    push_op.error = 1'b1;
                end else begin
                    n_doc = sum[DOC_W-1:0];
                    if (i_value[0]) begin
                        n_remaining  = rem_dec;
                        push_valid   = 1'b1;
                        push_op.code = OP_CHECK;
                        push_op.doc  = DOC_ADDR_MAX_W'(sum[DOC_W-1:0]);
                        push_op.freq = FREQ_W'(1);
                        push_op.last = is_last;
                    end else begin
                        n_awaiting = 1'b1;
                    end
                end
            end
            KIND_DELETE: begin
                push_valid = 1'b1;
                if (i_value >= MaxDocs) begin
                    push_op.code  = OP_EMIT;
                    push_op.error = 1'b1;
                end else begin
                    push_op.code = OP_DELETE;
                    push_op.doc  = i_value[DOC_ADDR_MAX_W-1:0];
                end
            end
            default: begin
            end
        endcase
        o_push.valid = accept && push_valid;
        o_push.op    = push_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doc       <= '0;
            r_remaining <= '0;
            r_awaiting  <= 1'b0;
        end else if (accept) begin
            r_doc       <= n_doc;
            r_remaining <= n_remaining;
            r_awaiting  <= n_awaiting;
        end
    end

endmodule

FILE: src/pdd_queue.sv
`timescale 1ns / 1ps
// Short operation queue between the front end and the back end.
module pdd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pdd_pkg::t_push        i_push,
    input  logic                  i_pop,
    output logic                  o_full,
    output pdd_pkg::t_queue_head  o_head
);
    import pdd_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

    t_op               r_slots [QUEUE_DEPTH];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic              do_pop;

    assign o_full       = (r_count == CntW'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.op    = r_slots[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slots[r_wr_ptr] <= i_push.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (i_push.valid && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (!i_push.valid && do_pop) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

FILE: src/pdd_back.sv
`timescale 1ns / 1ps
// Back end: deletion bitmap, lookup stage and output register.
module pdd_back #(
    parameter int MAX_DOCS = pdd_pkg::MAX_DOCS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pdd_pkg::t_queue_head        i_head,
    output logic                        o_pop,
    output pdd_pkg::t_back_status       o_status,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pdd_pkg::DOC_W-1:0]   o_doc_number,
    output logic [pdd_pkg::FREQ_W-1:0]  o_frequency,
    output logic                        o_present,
    output logic                        o_last,
    output logic                        o_error
);
    import pdd_pkg::*;

    localparam int AddrW = $clog2(MAX_DOCS);
    localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_DOCS - 1);

    logic              r_map [MAX_DOCS];
    logic              r_clr_busy;
    logic [AddrW-1:0]  r_clr_addr;
    logic              r_rd;
    logic              r_s1_valid;
    t_op               r_s1_op;
    logic              r_out_valid;

    logic              out_free;
    logic              s1_adv;
    logic              mem_we;
    logic [AddrW-1:0]  mem_waddr;
    logic              mem_wdata;
    logic              res_valid;
    logic [DOC_W-1:0]  res_doc;
    logic [FREQ_W-1:0] res_freq;
    logic              res_present;
    logic              res_last;
    logic              res_error;

    assign out_free = !r_out_valid || i_ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_pop    = i_head.valid && !r_clr_busy && (!r_s1_valid || s1_adv);
    assign o_status.clearing = r_clr_busy;

    assign mem_we    = r_clr_busy || (o_pop && i_head.op.code == OP_DELETE);
    assign mem_waddr = r_clr_busy ? r_clr_addr : i_head.op.doc[AddrW-1:0];
    assign mem_wdata = !r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rd <= r_map[i_head.op.doc[AddrW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LastAddr) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AddrW'(1);
            end
        end
    end

    always_comb begin
        res_valid   = 1'b0;
        res_doc     = '0;
        res_freq    = '0;
        res_present = 1'b0;
        res_last    = 1'b0;
        res_error   = 1'b0;
        case (r_s1_op.code)
            OP_EMIT: begin
                res_valid = 1'b1;
                res_last  = r_s1_op.last;
                res_error = r_s1_op.error;
            end
            OP_CHECK: begin
                if (!r_rd) begin
                    res_valid   = 1'b1;
                    res_doc     = r_s1_op.doc[DOC_W-1:0];
                    res_freq    = r_s1_op.freq;
                    res_present = 1'b1;
                    res_last    = r_s1_op.last;
                end else if (r_s1_op.last) begin
                    res_valid = 1'b1;
                    res_last  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= s1_adv && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_op <= i_head.op;
        end
        if (s1_adv && res_valid) begin
            o_doc_number <= res_doc;
            o_frequency  <= res_freq;
            o_present    <= res_present;
            o_last       <= res_last;
            o_error      <= res_error;
        end
    end

    assign o_valid = r_out_valid;

endmodule

FILE: src/postings_delta_decoder_core.sv
`timescale 1ns / 1ps
// Top level of the postings delta decoder.
//
// Input channel: i_valid / o_ready with i_kind and i_value. Kind 0 starts a
// term with a posting count, kind 1 is a postings stream word and kind 2
// marks a document as deleted. Output channel: o_valid / i_ready carrying
// one result item per undeleted posting, error or end-of-term marker.
//
// An item is accepted in any cycle in which the operation queue has room and
// the bitmap is not being cleared, so while the receiver keeps up the
// sustained rate is one item per cycle. A result passes through the queue
// and the bitmap lookup stage and is then held in the output register.
//
// After reset the deletion bitmap is cleared one entry per cycle; o_ready
// stays low until that pass is over.
// When the receiver stalls, the output register and lookup stage hold and
// the four-entry queue absorbs further items before o_ready falls.
module postings_delta_decoder_core #(
    parameter int MAX_DOCS = pdd_pkg::MAX_DOCS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [pdd_pkg::KIND_W-1:0]  i_kind,
    input  logic [pdd_pkg::WORD_W-1:0]  i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pdd_pkg::DOC_W-1:0]   o_doc_number,
    output logic [pdd_pkg::FREQ_W-1:0]  o_frequency,
    output logic                        o_present,
    output logic                        o_last,
    output logic                        o_error
);
    import pdd_pkg::*;

    t_push        push;
    t_queue_head  head;
    t_back_status back_status;
    logic         queue_full;
    logic         pop;

    pdd_front #(
        .MAX_DOCS (MAX_DOCS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .o_ready       (o_ready),
        .i_back_status (back_status),
        .i_queue_full  (queue_full),
        .o_push        (push)
    );

    pdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    pdd_back #(
        .MAX_DOCS (MAX_DOCS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_status     (back_status),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_doc_number (o_doc_number),
        .o_frequency  (o_frequency),
        .o_present    (o_present),
        .o_last       (o_last),
        .o_error      (o_error)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the postings delta decoder core, with a scoreboard class.
module tb_top;
    import pdd_pkg::*;

    localparam int MAX_DOCS  = MAX_DOCS_DEFAULT;
    localparam int DOC_LIMIT = (MAX_DOCS < DOC_SPACE) ? MAX_DOCS : DOC_SPACE;
    localparam int ITEM_GOAL = 1700;

    typedef struct packed {
        logic [DOC_W-1:0]  doc;
        logic [FREQ_W-1:0] freq;
        logic              present;
        logic              last;
        logic              err;
    } t_posting;

    class postings_tracker;
        logic [DOC_W-1:0]  cur_doc;
        logic [WORD_W-1:0] remaining;
        bit                awaiting_freq;
        bit                doc_deleted [MAX_DOCS];
        t_posting          pending_results [$];
        int                mismatches;

        function new();
            cur_doc       = '0;
            remaining     = '0;
            awaiting_freq = 1'b0;
            mismatches    = 0;
            foreach (doc_deleted[i]) doc_deleted[i] = 1'b0;
        endfunction

        function void queue_result(logic [DOC_W-1:0] doc, logic [FREQ_W-1:0] freq,
                                   logic present, logic last, logic err);
            t_posting res;
            res.doc     = doc;
            res.freq    = freq;
            res.present = present;
            res.last    = last;
            res.err     = err;
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void finish_posting(logic [FREQ_W-1:0] freq);
            logic last;
            remaining = remaining - 1;
            last      = (remaining == 0);
            if (!doc_deleted[cur_doc])
                queue_result(cur_doc, freq, 1'b1, last, 1'b0);
            else if (last)
                queue_result('0, '0, 1'b0, 1'b1, 1'b0);
        endfunction

        function void note_item(t_kind kind, logic [WORD_W-1:0] value);
            logic [WORD_W:0] sum;
            case (kind)
                KIND_START: begin
                    remaining     = value;
                    cur_doc       = '0;
                    awaiting_freq = 1'b0;
                end
                KIND_WORD: begin
                    if (awaiting_freq) begin
                        awaiting_freq = 1'b0;
                        finish_posting(value);
                    end else if (remaining == 0) begin
                        queue_result('0, '0, 1'b0, 1'b0, 1'b1);
                    end else begin
                        sum = {17'd0, cur_doc} + {2'd0, value[WORD_W-1:1]};
                        if (sum >= DOC_LIMIT) begin
                            remaining     = '0;
                            awaiting_freq = 1'b0;
                            queue_result('0, '0, 1'b0, 1'b1, 1'b1);
                        end else begin
                            cur_doc = sum[DOC_W-1:0];
                            if (value[0])
                                finish_posting(1);
                            else
                                awaiting_freq = 1'b1;
                        end
                    end
                end
                KIND_DELETE: begin
                    if (value >= MAX_DOCS)
                        queue_result('0, '0, 1'b0, 1'b0, 1'b1);
                    else
                        doc_deleted[value] = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_posting(t_posting got);
            t_posting want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: doc %0h freq %0h present %0b last %0b error %0b",
                       got.doc, got.freq, got.present, got.last, got.err);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("doc_number", want.doc, got.doc);
                compare_field("frequency", want.freq, got.freq);
                compare_field("present", want.present, got.present);
                compare_field("last", want.last, got.last);
                compare_field("error", want.err, got.err);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [KIND_W-1:0]   i_kind  = KIND_NONE;
    logic [WORD_W-1:0]   i_value = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [DOC_W-1:0]    o_doc_number;
    logic [FREQ_W-1:0]   o_frequency;
    logic                o_present;
    logic                o_last;
    logic                o_error;

    postings_tracker tracker;
    int              send_idle_pct = 0;
    int              stall_pct     = 0;
    int              items_sent    = 0;

    postings_delta_decoder_core #(
        .MAX_DOCS(MAX_DOCS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_doc_number (o_doc_number),
        .o_frequency  (o_frequency),
        .o_present    (o_present),
        .o_last       (o_last),
        .o_error      (o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_posting({o_doc_number, o_frequency, o_present, o_last, o_error});
    end

    task automatic send_item(input t_kind kind, input logic [WORD_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.note_item(kind, value);
        if (kind != KIND_NONE)
            items_sent++;
    endtask

    task automatic send_term();
        int                count;
        int                doc_est;
        int                k;
        logic [30:0]       delta;
        logic              freq_one;
        logic [FREQ_W-1:0] freq;
        count = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        doc_est = 0;
        send_item(KIND_START, count);
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 7) == 0)
                send_item(KIND_DELETE, doc_est + $urandom_range(0, 60));
            case ($urandom_range(0, 59))
                0:       delta = 31'($urandom);
                1, 2:    delta = '0;
                default: delta = 31'($urandom_range(1, 40));
            endcase
            doc_est  = doc_est + delta;
            freq_one = $urandom_range(0, 1);
            send_item(KIND_WORD, {delta, freq_one});
            if (!freq_one) begin
                if ($urandom_range(0, 29) == 0)
                    return;
                freq = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20);
                send_item(KIND_WORD, freq);
            end
        end
        if ($urandom_range(0, 9) == 0)
            send_item(KIND_WORD, $urandom);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0:       send_item(t_kind'($urandom_range(0, 3)), $urandom);
            1:       send_item(KIND_DELETE, $urandom_range(0, 1023));
            2:       send_item(KIND_WORD, $urandom);
            default: send_item(KIND_DELETE, $urandom_range(MAX_DOCS - 6, MAX_DOCS + 6));
        endcase
    endtask

    initial begin
        int phase;
        int goal;
        tracker = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: extremes, every kind and the corner cases of the decoder.
        send_item(KIND_WORD, 32'd5);
        send_item(KIND_NONE, 32'hFFFF_FFFF);
        send_item(KIND_DELETE, 32'd0);
        send_item(KIND_DELETE, 32'd65535);
        send_item(KIND_DELETE, 32'd65536);
        send_item(KIND_DELETE, 32'hFFFF_FFFF);
        send_item(KIND_START, 32'd3);
        send_item(KIND_WORD, 32'd1);
        send_item(KIND_WORD, 32'd4);
        send_item(KIND_WORD, 32'hFFFF_FFFF);
        send_item(KIND_WORD, (32'd65533 << 1) | 32'd1);
        send_item(KIND_WORD, 32'd7);
        send_item(KIND_START, 32'd0);
        send_item(KIND_WORD, 32'd3);
        send_item(KIND_START, 32'd2);
        send_item(KIND_WORD, 32'd10);
        send_item(KIND_START, 32'd1);
        send_item(KIND_WORD, 32'd0);
        send_item(KIND_WORD, 32'd0);
        send_item(KIND_START, 32'd2);
        send_item(KIND_WORD, (32'd65535 << 1) | 32'd1);
        send_item(KIND_WORD, 32'd3);
        send_item(KIND_WORD, 32'd9);
        send_item(KIND_START, 32'hFFFF_FFFF);
        send_item(KIND_WORD, 32'd2);
        send_item(KIND_WORD, 32'h1234_5678);
        send_item(KIND_WORD, 32'hFFFF_FFFE);

        goal = items_sent;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 69; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            goal = goal + ITEM_GOAL / 4;
            while (items_sent < goal) begin
                if ($urandom_range(0, 6) == 0)
                    send_noise();
                else
                    send_term();
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: files.f
src/pdd_pkg.sv
src/pdd_front.sv
src/pdd_queue.sv
src/pdd_back.sv
src/postings_delta_decoder_core.sv
tb/sv/tb_top.sv
